// ===== rtl/pcgbr_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package pcgbr_pkg;

   localparam int ValueWidth    = 32;
   localparam int StateWidth    = 64;
   localparam int RegIndexWidth = 1;

   localparam logic [RegIndexWidth-1:0] RegSeed      = 1'd0;
   localparam logic [RegIndexWidth-1:0] RegIncrement = 1'd1;

   localparam logic [StateWidth-1:0] LcgMult  = 64'd6364136223846793005;
   localparam logic [StateWidth-1:0] IncReset = 64'd1442695040888963407;
   // state after seeding with seed zero and the reset increment
   localparam logic [StateWidth-1:0] GenReset = IncReset * LcgMult + IncReset;

   localparam int XshShiftA = 18;
   localparam int XshShiftB = 27;
   localparam int RotShift  = 59;

   localparam int RejectLimit   = 1024;
   localparam int TriesWidth    = $clog2(RejectLimit);
   localparam int DivCountWidth = $clog2(ValueWidth);

   typedef enum logic [1:0] {
      OUT_ZERO,
      OUT_RAW,
      OUT_MOD
   } out_sel_type;

   typedef enum logic {
      DIV_SRC_THRESHOLD,
      DIV_SRC_VALUE
   } div_src_type;

   typedef enum logic [1:0] {
      MUL_LL,
      MUL_HL,
      MUL_LH
   } mul_sel_type;

   typedef enum logic [1:0] {
      ACC_HOLD,
      ACC_LOAD,
      ACC_ADD
   } acc_op_type;

   typedef struct packed {
      logic        load_req;
      logic        div_start;
      div_src_type div_src;
      logic        div_step;
      logic        take_value;
      mul_sel_type mul_sel;
      acc_op_type  acc_op;
      logic        step_draw;
      logic        commit_seed;
      logic        commit;
      logic        set_exh;
      logic        reject;
      logic        out_load;
      out_sel_type out_sel;
      logic        out_err;
   } dp_cmd_type;

   typedef struct packed {
      logic seed_wr;
      logic action;
      logic trivial;
      logic exhausted;
      logic cnt_max;
      logic v_ok;
      logic tries_last;
      logic div_last;
   } dp_status_type;

endpackage

`default_nettype wire

// ===== rtl/pcgbr_dp.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcgbr_dp import pcgbr_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tuser,
   input  wire logic [ValueWidth-1:0]    req_tdata,
   input  wire logic                     csr_wr_en,
   input  wire logic [RegIndexWidth-1:0] csr_index,
   input  wire logic [StateWidth-1:0]    csr_wdata,
   input  wire dp_cmd_type               cmd,
   output dp_status_type                 status,
   output logic [ValueWidth-1:0]         rsp_tdata,
   output logic                          rsp_tuser
);

   localparam int HalfWidth = StateWidth / 2;

   logic [StateWidth-1:0]    increment_ff, increment_in;
   logic [StateWidth-1:0]    reseed_inc_ff, reseed_inc_in;
   logic [StateWidth-1:0]    gen_state_ff, gen_state_in;
   logic [StateWidth-1:0]    draw_count_ff, draw_count_in;
   logic                     exhausted_ff, exhausted_in;
   logic                     action_ff, action_in;
   logic [ValueWidth-1:0]    bound_ff, bound_in;
   logic [StateWidth-1:0]    work_s_ff, work_s_in;
   logic [StateWidth-1:0]    work_cnt_ff, work_cnt_in;
   logic [TriesWidth-1:0]    tries_ff, tries_in;
   logic [ValueWidth-1:0]    v_ff, v_in;
   logic [StateWidth-1:0]    prod_ff, prod_in;
   logic [StateWidth-1:0]    acc_ff, acc_in;
   logic [ValueWidth-1:0]    rem_ff, rem_in;
   logic [ValueWidth-1:0]    dq_ff, dq_in;
   logic [DivCountWidth-1:0] div_cnt_ff, div_cnt_in;
   logic [ValueWidth-1:0]    value_ff, value_in;
   logic                     err_ff, err_in;

   logic                     seed_wr;
   logic [HalfWidth-1:0]     mul_a;
   logic [HalfWidth-1:0]     mul_b;
   logic [StateWidth-1:0]    step_sum;
   logic [ValueWidth:0]      div_trial;
   logic [ValueWidth-1:0]    permuted;
   logic [StateWidth-1:0]    xs_wide;
   logic [ValueWidth-1:0]    xs;
   logic [4:0]               rot;
   logic [4:0]               rot_neg;

   assign seed_wr = csr_wr_en && (csr_index == RegSeed);

   // XSH-RR output permutation of the pre-step state
   always_comb begin
      xs_wide  = ((work_s_ff >> XshShiftA) ^ work_s_ff) >> XshShiftB;
      xs       = xs_wide[ValueWidth-1:0];
      rot      = work_s_ff[RotShift +: 5];
      rot_neg  = 5'd0 - rot;
      permuted = (xs >> rot) | (xs << rot_neg);
   end

   assign mul_a = (cmd.mul_sel == MUL_HL) ? work_s_ff[StateWidth-1:HalfWidth]
                                          : work_s_ff[HalfWidth-1:0];
   assign mul_b = (cmd.mul_sel == MUL_LH) ? LcgMult[StateWidth-1:HalfWidth]
                                          : LcgMult[HalfWidth-1:0];

   assign step_sum = acc_ff + (cmd.commit_seed ? reseed_inc_ff : increment_ff);
   assign div_trial = {rem_ff, dq_ff[ValueWidth-1]};

   always_comb begin
      increment_in  = increment_ff;
      reseed_inc_in = reseed_inc_ff;
      gen_state_in  = gen_state_ff;
      draw_count_in = draw_count_ff;
      exhausted_in  = exhausted_ff;
      action_in     = action_ff;
      bound_in      = bound_ff;
      work_s_in     = work_s_ff;
      work_cnt_in   = work_cnt_ff;
      tries_in      = tries_ff;
      v_in          = v_ff;
      prod_in       = {{HalfWidth{1'b0}}, mul_a} * {{HalfWidth{1'b0}}, mul_b};
      acc_in        = acc_ff;
      rem_in        = rem_ff;
      dq_in         = dq_ff;
      div_cnt_in    = div_cnt_ff;
      value_in      = value_ff;
      err_in        = err_ff;

      if (csr_wr_en && (csr_index == RegIncrement)) begin
         increment_in = csr_wdata;
      end

      if (cmd.load_req) begin
         action_in   = req_tuser;
         bound_in    = req_tdata;
         work_s_in   = gen_state_ff;
         work_cnt_in = draw_count_ff;
         tries_in    = '0;
      end

      if (cmd.take_value) begin
         v_in = permuted;
      end

      case (cmd.acc_op)
         ACC_LOAD: acc_in = prod_ff;
         ACC_ADD:  acc_in = {acc_ff[StateWidth-1:HalfWidth] + prod_ff[HalfWidth-1:0],
                             acc_ff[HalfWidth-1:0]};
         default:  acc_in = acc_ff;
      endcase

      if (cmd.step_draw) begin
         work_s_in   = step_sum;
         work_cnt_in = work_cnt_ff + 1'b1;
      end

      if (cmd.commit_seed) begin
         gen_state_in = step_sum;
      end

      if (cmd.commit) begin
         gen_state_in  = work_s_ff;
         draw_count_in = work_cnt_ff;
      end

      if (cmd.set_exh) begin
         exhausted_in = 1'b1;
      end

      if (cmd.reject) begin
         tries_in = tries_ff + 1'b1;
      end

      // seeding: advance from zero gives the increment, then add the seed
      if (seed_wr) begin
         work_s_in     = increment_ff + csr_wdata;
         reseed_inc_in = increment_ff;
      end

      if (cmd.div_start) begin
         rem_in     = '0;
         dq_in      = (cmd.div_src == DIV_SRC_THRESHOLD) ? (ValueWidth'(0) - bound_ff) : v_ff;
         div_cnt_in = '0;
      end else if (cmd.div_step) begin
         if (div_trial >= {1'b0, bound_ff}) begin
            rem_in = ValueWidth'(div_trial - {1'b0, bound_ff});
         end else begin
            rem_in = div_trial[ValueWidth-1:0];
         end
         dq_in      = {dq_ff[ValueWidth-2:0], 1'b0};
         div_cnt_in = div_cnt_ff + 1'b1;
      end

      if (cmd.out_load) begin
         case (cmd.out_sel)
            OUT_RAW: value_in = v_ff;
            OUT_MOD: value_in = rem_ff;
            default: value_in = '0;
         endcase
         err_in = cmd.out_err;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         increment_ff  <= IncReset;
         gen_state_ff  <= GenReset;
         draw_count_ff <= '0;
         exhausted_ff  <= 1'b0;
      end else begin
         increment_ff  <= increment_in;
         gen_state_ff  <= gen_state_in;
         draw_count_ff <= draw_count_in;
         exhausted_ff  <= exhausted_in;
      end
   end

   always_ff @(posedge clock) begin
      reseed_inc_ff <= reseed_inc_in;
      action_ff     <= action_in;
      bound_ff      <= bound_in;
      work_s_ff     <= work_s_in;
      work_cnt_ff   <= work_cnt_in;
      tries_ff      <= tries_in;
      v_ff          <= v_in;
      prod_ff       <= prod_in;
      acc_ff        <= acc_in;
      rem_ff        <= rem_in;
      dq_ff         <= dq_in;
      div_cnt_ff    <= div_cnt_in;
      value_ff      <= value_in;
      err_ff        <= err_in;
   end

   always_comb begin
      status.seed_wr    = seed_wr;
      status.action     = action_ff;
      status.trivial    = action_ff && (bound_ff <= ValueWidth'(1));
      status.exhausted  = exhausted_ff;
      status.cnt_max    = &work_cnt_ff;
      // the threshold sits in the remainder until the final modulo starts
      status.v_ok       = (v_ff >= rem_ff);
      status.tries_last = (tries_ff == TriesWidth'(RejectLimit - 1));
      status.div_last   = (div_cnt_ff == DivCountWidth'(ValueWidth - 1));
   end

   assign rsp_tdata = value_ff;
   assign rsp_tuser = err_ff;

endmodule

`default_nettype wire

// ===== rtl/pcgbr_ctrl.sv =====
`timescale 1ns / 1ps
`default_nettype none

module pcgbr_ctrl import pcgbr_pkg::*; (
   input  wire logic          clock,
   input  wire logic          reset,
   input  wire logic          req_tvalid,
   output logic               req_tready,
   output logic               rsp_tvalid,
   input  wire logic          rsp_tready,
   input  wire dp_status_type status,
   output dp_cmd_type         cmd
);

   typedef enum logic [3:0] {
      ST_IDLE,
      ST_DECIDE,
      ST_DIV_THR,
      ST_DRAW,
      ST_MUL1,
      ST_MUL2,
      ST_MUL3,
      ST_STEP,
      ST_CHECK,
      ST_DIV_RES,
      ST_FINISH
   } state_type;

   state_type   state_ff, state_in;
   logic        seeding_ff, seeding_in;
   logic        rsp_tvalid_ff, rsp_tvalid_in;
   out_sel_type res_sel_ff, res_sel_in;
   logic        res_err_ff, res_err_in;

   assign req_tready = (state_ff == ST_IDLE) && !status.seed_wr;
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      state_in      = state_ff;
      seeding_in    = seeding_ff;
      rsp_tvalid_in = rsp_tvalid_ff && !rsp_tready;
      res_sel_in    = res_sel_ff;
      res_err_in    = res_err_ff;
      cmd           = '0;

      case (state_ff)
         ST_IDLE: begin
            if (req_tvalid && req_tready) begin
               cmd.load_req = 1'b1;
               state_in     = ST_DECIDE;
            end
         end
         ST_DECIDE: begin
            if (status.trivial) begin
               res_sel_in = OUT_ZERO;
               res_err_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (status.exhausted) begin
               res_sel_in = OUT_ZERO;
               res_err_in = 1'b1;
               state_in   = ST_FINISH;
            end else if (status.action) begin
               cmd.div_start = 1'b1;
               cmd.div_src   = DIV_SRC_THRESHOLD;
               state_in      = ST_DIV_THR;
            end else begin
               state_in = ST_DRAW;
            end
         end
         ST_DIV_THR: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               state_in = ST_DRAW;
            end
         end
         ST_DRAW: begin
            if (!seeding_ff && status.cnt_max) begin
               cmd.set_exh = 1'b1;
               res_sel_in  = OUT_ZERO;
               res_err_in  = 1'b1;
               state_in    = ST_FINISH;
            end else begin
               cmd.take_value = 1'b1;
               cmd.mul_sel    = MUL_LL;
               state_in       = ST_MUL1;
            end
         end
         ST_MUL1: begin
            cmd.mul_sel = MUL_HL;
            cmd.acc_op  = ACC_LOAD;
            state_in    = ST_MUL2;
         end
         ST_MUL2: begin
            cmd.mul_sel = MUL_LH;
            cmd.acc_op  = ACC_ADD;
            state_in    = ST_MUL3;
         end
         ST_MUL3: begin
            cmd.acc_op = ACC_ADD;
            state_in   = ST_STEP;
         end
         ST_STEP: begin
            if (seeding_ff) begin
               cmd.commit_seed = 1'b1;
               seeding_in      = 1'b0;
               state_in        = ST_IDLE;
            end else begin
               cmd.step_draw = 1'b1;
               state_in      = ST_CHECK;
            end
         end
         ST_CHECK: begin
            if (!status.action) begin
               cmd.commit = 1'b1;
               res_sel_in = OUT_RAW;
               res_err_in = 1'b0;
               state_in   = ST_FINISH;
            end else if (status.v_ok) begin
               cmd.commit    = 1'b1;
               cmd.div_start = 1'b1;
               cmd.div_src   = DIV_SRC_VALUE;
               state_in      = ST_DIV_RES;
            end else if (status.tries_last) begin
               // give up without committing anything
               res_sel_in = OUT_ZERO;
               res_err_in = 1'b1;
               state_in   = ST_FINISH;
            end else begin
               cmd.reject = 1'b1;
               state_in   = ST_DRAW;
            end
         end
         ST_DIV_RES: begin
            cmd.div_step = 1'b1;
            if (status.div_last) begin
               res_sel_in = OUT_MOD;
               res_err_in = 1'b0;
               state_in   = ST_FINISH;
            end
         end
         ST_FINISH: begin
            // hold until the output register is free
            if (!rsp_tvalid_ff || rsp_tready) begin
               cmd.out_load  = 1'b1;
               cmd.out_sel   = res_sel_ff;
               cmd.out_err   = res_err_ff;
               rsp_tvalid_in = 1'b1;
               state_in      = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase

      // a seed write while idle or seeding starts the seeding sequence anew
      if (status.seed_wr && ((state_ff == ST_IDLE) || seeding_ff)) begin
         seeding_in = 1'b1;
         state_in   = ST_DRAW;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= ST_IDLE;
         seeding_ff    <= 1'b0;
         rsp_tvalid_ff <= 1'b0;
         res_sel_ff    <= OUT_ZERO;
         res_err_ff    <= 1'b0;
      end else begin
         state_ff      <= state_in;
         seeding_ff    <= seeding_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
         res_sel_ff    <= res_sel_in;
         res_err_ff    <= res_err_in;
      end
   end

   a_one_at_a_time: assert property (@(posedge clock) disable iff (reset)
      (req_tvalid && req_tready) |=> !req_tready)
      else $error("second transfer accepted while a request is in flight");

   a_no_overwrite: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |-> (!rsp_tvalid_ff || rsp_tready))
      else $error("pending result overwritten");

   a_load_shows: assert property (@(posedge clock) disable iff (reset)
      cmd.out_load |=> rsp_tvalid_ff)
      else $error("loaded result not presented");

   a_seed_restart: assert property (@(posedge clock) disable iff (reset)
      (status.seed_wr && (state_ff == ST_IDLE)) |=> (seeding_ff && (state_ff == ST_DRAW)))
      else $error("seed write did not start seeding");

endmodule

`default_nettype wire

// ===== rtl/pcg32_bounded_random.sv =====
`timescale 1ns / 1ps
`default_nettype none

// PCG32 (XSH-RR) random source with unbiased bounded draws.
// Request channel: req_tuser selects the kind (0 raw 32-bit, 1 bounded),
// req_tdata carries the exclusive upper bound. Response channel: rsp_tdata
// is the value, rsp_tuser flags a failed request (value then zero).
// csr_wr_en/csr_index/csr_wdata write seed (index 0) or increment (index 1).
// A seed write reseeds the state through an LCG step; req_tready is low then.
// One request is in flight at a time. Trivial bound or exhausted: straight
// to the result; raw: one draw; bounded: threshold division, then draws
// (one draw usually, more when rejected), then the result division. Both
// divisions run in the bit-serial remainder unit; each LCG step takes
// three passes through the shared 32x32 multiplier.
// Reset loads the state for seed zero directly, so no seeding pass follows.
// A finished result sits in the output register; if rsp_tready is low the
// block accepts the next request and holds its result until the slot frees.
module pcg32_bounded_random import pcgbr_pkg::*; (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_tvalid,
   output logic                          req_tready,
   input  wire logic [ValueWidth-1:0]    req_tdata,   // [31:0] upper_bound
   input  wire logic                     req_tuser,   // [0] action
   output logic                          rsp_tvalid,
   input  wire logic                     rsp_tready,
   output logic [ValueWidth-1:0]         rsp_tdata,   // [31:0] random_value
   output logic                          rsp_tuser,   // [0] exhausted_error
   input  wire logic                     csr_wr_en,
   input  wire logic [RegIndexWidth-1:0] csr_index,
   input  wire logic [StateWidth-1:0]    csr_wdata
);

   dp_cmd_type    cmd;
   dp_status_type status;

   pcgbr_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   pcgbr_dp u_dp (
      .clock     (clock),
      .reset     (reset),
      .req_tuser (req_tuser),
      .req_tdata (req_tdata),
      .csr_wr_en (csr_wr_en),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cmd       (cmd),
      .status    (status),
      .rsp_tdata (rsp_tdata),
      .rsp_tuser (rsp_tuser)
   );

endmodule

`default_nettype wire
